// ===== hw/rtl/b2bcd_pkg.sv =====
// Shared constants and controller-to-datapath types for the binary to BCD converter.
`default_nettype none

package b2bcd_pkg;

    localparam int DEF_BIN_WIDTH  = 64;
    localparam int DEF_MAX_DIGITS = 20;
    localparam int VALUE_W        = 64;
    localparam int DIGIT_W        = 4;
    localparam int POS_W          = 5;

    typedef struct packed {
        logic load;
        logic dabble;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic rest_zero;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/binary_to_bcd_digits_core.sv =====
// Top level: binary to BCD digit converter with command-style start/busy handshake.
`default_nettype none

// Converts one unsigned value (low BIN_WIDTH bits of i_value) to decimal and
// sends its digits least significant first, one per cycle on o_strobe, with
// o_last on the most significant digit; zero gives a single digit 0, and at
// most MAX_DIGITS digits are sent. A transfer in takes place when start is high
// and busy is low. The double-dabble datapath consumes one input bit per cycle,
// so conversion steps through all BIN_WIDTH input bits and then sends the
// digits; busy stays high, and no new value is taken, until the last digit is sent. The
// receiver cannot stall: each digit is on the ports for exactly one cycle.
module binary_to_bcd_digits_core
    import b2bcd_pkg::*;
#(
    parameter int BIN_WIDTH  = DEF_BIN_WIDTH,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_strobe,
    output logic      [DIGIT_W-1:0] o_digit,
    output logic      [POS_W-1:0]   o_digit_position,
    output logic                    o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    b2bcd_ctrl #(
        .BIN_WIDTH  (BIN_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_pos    (o_digit_position),
        .o_last   (o_last)
    );

    b2bcd_dp #(
        .BIN_WIDTH (BIN_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_value (i_value),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_digit (o_digit)
    );

    a_start_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_strobe)
        else $error("transfer in did not start a conversion");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_digit <= DIGIT_W'(9))
        else $error("digit out of decimal range");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe &&
            o_digit_position == POS_W'($past(o_digit_position) + POS_W'(1)))
        else $error("digit run broken or position skipped");

    a_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !busy && !o_strobe)
        else $error("block stayed busy after last digit");

endmodule

`default_nettype wire

// ===== hw/rtl/b2bcd_dp.sv =====
// Datapath: binary shift register, BCD digit register with add-3 correction and digit unload.
`default_nettype none

module b2bcd_dp
    import b2bcd_pkg::*;
#(
    parameter int BIN_WIDTH = DEF_BIN_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    output logic      [DIGIT_W-1:0] o_digit
);

    localparam int NDIG  = (BIN_WIDTH * 31) / 100 + 1;
    localparam int BCD_W = NDIG * DIGIT_W;

    logic [BIN_WIDTH-1:0] r_bin;
    logic [BIN_WIDTH-1:0] n_bin;
    logic [BCD_W-1:0]     r_bcd;
    logic [BCD_W-1:0]     n_bcd;
    logic [BCD_W-1:0]     adj;

    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            if (r_bcd[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adj[k*DIGIT_W +: DIGIT_W] = r_bcd[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                adj[k*DIGIT_W +: DIGIT_W] = r_bcd[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_cmd.load) begin
            n_bin = i_value[BIN_WIDTH-1:0];
            n_bcd = '0;
        end else if (i_cmd.dabble) begin
            n_bin = {r_bin[BIN_WIDTH-2:0], 1'b0};
            n_bcd = {adj[BCD_W-2:0], r_bin[BIN_WIDTH-1]};
        end else if (i_cmd.emit) begin
            n_bcd = {{DIGIT_W{1'b0}}, r_bcd[BCD_W-1:DIGIT_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_digit         = r_bcd[DIGIT_W-1:0];
    assign o_sts.rest_zero = (r_bcd[BCD_W-1:DIGIT_W] == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/b2bcd_ctrl.sv =====
// Controller: sequences load, one conversion step per input bit, then digit unload.
`default_nettype none

module b2bcd_ctrl
    import b2bcd_pkg::*;
#(
    parameter int BIN_WIDTH  = DEF_BIN_WIDTH,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_dp_sts          i_sts,
    output t_dp_cmd               o_cmd,
    output logic                  o_busy,
    output logic                  o_strobe,
    output logic      [POS_W-1:0] o_pos,
    output logic                  o_last
);

    localparam int CNT_W = $clog2(BIN_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             last;

    assign last = i_sts.rest_zero || (r_pos == POS_W'(MAX_DIGITS - 1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_pos      = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.dabble = 1'b1;
                n_cnt        = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(BIN_WIDTH - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_pos      = r_pos + POS_W'(1);
                if (last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_EMIT);
    assign o_pos    = r_pos;
    assign o_last   = last;

endmodule

`default_nettype wire
